### rtl/http_request_line_parser_top_macros.svh
// Assertion macros for the request line parser back end.
`ifndef HTTP_REQUEST_LINE_PARSER_TOP_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_TOP_MACROS_SVH

// Plain property, checked on every clock edge out of reset.
`define HRLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define HRLP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

### rtl/hrlp_pkg.sv
// Types and constants of the request line parser.
`default_nettype none

package hrlp_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_CNT_W = 3;
  localparam int unsigned RES_IDX_W = 2;

  // Parser phases
  typedef enum logic [3:0] {
    PH_METHOD0  = 4'd0,
    PH_METHOD   = 4'd1,
    PH_URL0     = 4'd2,
    PH_URL      = 4'd3,
    PH_ESC1     = 4'd4,
    PH_ESC2     = 4'd5,
    PH_QUERY    = 4'd6,
    PH_VERSION  = 4'd7,
    PH_MAJOR0   = 4'd8,
    PH_MAJOR    = 4'd9,
    PH_MAJOR_SP = 4'd10,
    PH_MINOR0   = 4'd11,
    PH_MINOR    = 4'd12,
    PH_END      = 4'd13,
    PH_DONE     = 4'd14,
    PH_ERROR    = 4'd15
  } phase_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_METHOD = 3'd0,
    KIND_URL    = 3'd1,
    KIND_QUERY  = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  localparam logic ERR_BAD   = 1'b0;
  localparam logic ERR_LARGE = 1'b1;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_A  = 8'h61;

  // Separators allowed in a method token
  localparam int unsigned NUM_SEP = 17;
  localparam logic [NUM_SEP-1:0][7:0] SEP_CHARS = {
    8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
    8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D
  };

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] major_version;
    logic [7:0] minor_version;
    logic       error_code;
    logic       last;
  } res_t;

  // All results caused by one byte
  typedef struct packed {
    logic [RES_CNT_W-1:0]  cnt;
    res_t [MAX_RES-1:0]    res;
  } bundle_t;

  // Front to back enqueue request
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } enq_t;

  // Decision for a byte in the URL body
  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    phase_e     phase;
    logic       bad;
    logic       done;
  } url_act_t;

endpackage

`default_nettype wire

### rtl/hrlp_front.sv
// Front end: parser state machine that classifies each byte into a result bundle.
`default_nettype none

module hrlp_front
  import hrlp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire req_t             req_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output enq_t                  enq_o
);

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_uc_hex(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h46);
  endfunction

  function automatic logic is_lc_hex(logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    return is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic is_method(logic [7:0] c);
    logic hit;
    hit = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    for (int i = 0; i < NUM_SEP; i++) begin
      if (SEP_CHARS[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  // acc * 10 + digit, clamped to 255
  function automatic logic [7:0] sat_digit(logic [7:0] acc, logic [7:0] c);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, c[3:0]};
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic url_act_t url_step(logic [7:0] c);
    url_act_t a;
    a = '{emit: 1'b0, ch: c, phase: PH_URL, bad: 1'b0, done: 1'b0};
    if (c == CH_QMARK)       a.phase = PH_QUERY;
    else if (c == CH_CR)     a.phase = PH_END;
    else if (c == CH_LF)     a.done  = 1'b1;
    else if (is_blank(c))    a.phase = PH_VERSION;
    else if (c == CH_PLUS) begin
      a.emit = 1'b1;
      a.ch   = CH_SP;
    end else if (c == CH_PCT) a.phase = PH_ESC1;
    else if ((c > CH_SP) && (c < CH_HIGH)) a.emit = 1'b1;
    else a.bad = 1'b1;
    return a;
  endfunction

  phase_e             phase_q, phase_d;
  logic [3:0]         nib_q, nib_d;
  logic               upper_q, upper_d;
  logic [7:0]         maj_q, maj_d;
  logic [7:0]         min_q, min_d;
  logic [31:0]        cnt_q, cnt_inc;
  logic [CFG_W-1:0]   max_q;

  logic [7:0]         c;
  logic               blank, digit, hex, live, too_big, bad, done, ev;
  url_act_t           u;
  logic [7:0]         esc_digit;
  kind_e              d_kind [3];
  logic [7:0]         d_ch   [3];
  logic [1:0]         d_n;
  logic [RES_CNT_W-1:0] n_tot;

  assign c     = req_i.data_byte;
  assign blank = is_blank(c);
  assign digit = is_digit(c);
  assign hex   = digit || is_uc_hex(c) || is_lc_hex(c);
  assign u     = url_step(c);
  assign live  = (phase_q != PH_DONE) && (phase_q != PH_ERROR);

  // Escape digit spelled back out when an escape breaks
  assign esc_digit = (nib_q < 4'd10) ? CH_ZERO + {4'h0, nib_q}
                   : (upper_q ? CH_UC_A : CH_LC_A) + {4'h0, nib_q - 4'd10};

  // Byte counter and limit check
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
  assign too_big = live && (max_q != '0) && (cnt_inc > max_q);
  assign ev      = live && (too_big || bad || done);

  // Output decode: field bytes and line events of this byte
  always_comb begin
    d_kind = '{KIND_URL, KIND_URL, KIND_URL};
    d_ch   = '{8'h00, 8'h00, 8'h00};
    d_n    = 2'd0;
    bad    = 1'b0;
    done   = 1'b0;
    unique case (phase_q)
      PH_METHOD0, PH_METHOD: begin
        if (is_method(c)) begin
          d_kind[0] = KIND_METHOD;
          d_ch[0]   = c;
          d_n       = 2'd1;
        end else if (phase_q == PH_METHOD0) begin
          bad = !blank;
        end else begin
          bad = (c != CH_SP);
        end
      end
      PH_URL0: begin
        if ((c > CH_SP) && (c < CH_HIGH)) begin
          d_ch[0] = c;
          d_n     = 2'd1;
        end else begin
          bad = !blank;
        end
      end
      PH_URL: begin
        d_ch[0] = u.ch;
        d_n     = {1'b0, u.emit};
        bad     = u.bad;
        done    = u.done;
      end
      PH_ESC1: begin
        if (!hex) begin
          d_ch[0] = CH_PCT;
          d_ch[1] = u.ch;
          d_n     = u.emit ? 2'd2 : 2'd1;
          bad     = u.bad;
          done    = u.done;
        end
      end
      PH_ESC2: begin
        if (hex) begin
          d_ch[0] = {nib_q, hex_val(c)};
          d_n     = 2'd1;
        end else begin
          d_ch[0] = CH_PCT;
          d_ch[1] = esc_digit;
          d_ch[2] = u.ch;
          d_n     = u.emit ? 2'd3 : 2'd2;
          bad     = u.bad;
          done    = u.done;
        end
      end
      PH_QUERY: begin
        if (!blank) begin
          d_kind[0] = KIND_QUERY;
          d_ch[0]   = c;
          d_n       = 2'd1;
        end
      end
      PH_VERSION:  bad = (c == CH_CR);
      PH_MAJOR0, PH_MAJOR: bad = !((c == CH_DOT) || digit || blank);
      PH_MAJOR_SP: bad = (c != CH_DOT);
      PH_MINOR0, PH_MINOR: begin
        done = (c == CH_LF);
        bad  = !((c == CH_LF) || (c == CH_CR) || digit || blank);
      end
      PH_END: begin
        done = (c == CH_LF);
        bad  = !((c == CH_LF) || blank);
      end
      default: ;
    endcase
  end

  // Next state of the parser
  always_comb begin
    phase_d = phase_q;
    nib_d   = nib_q;
    upper_d = upper_q;
    maj_d   = maj_q;
    min_d   = min_q;
    unique case (phase_q)
      PH_METHOD0:  if (is_method(c)) phase_d = PH_METHOD;
      PH_METHOD:   if (!is_method(c) && (c == CH_SP)) phase_d = PH_URL0;
      PH_URL0:     if ((c > CH_SP) && (c < CH_HIGH)) phase_d = PH_URL;
      PH_URL:      phase_d = u.phase;
      PH_ESC1: begin
        if (hex) begin
          nib_d   = hex_val(c);
          upper_d = is_uc_hex(c);
          phase_d = PH_ESC2;
        end else begin
          phase_d = u.phase;
        end
      end
      PH_ESC2: begin
        nib_d   = 4'h0;
        upper_d = 1'b0;
        phase_d = hex ? PH_URL : u.phase;
      end
      PH_QUERY:    if (blank) phase_d = PH_VERSION;
      PH_VERSION: begin
        if (c == CH_SLASH) begin
          maj_d   = 8'h00;
          min_d   = 8'h00;
          phase_d = PH_MAJOR0;
        end
      end
      PH_MAJOR0, PH_MAJOR: begin
        if (!((phase_q == PH_MAJOR0) && blank)) begin
          phase_d = PH_MAJOR;
          if (c == CH_DOT)  phase_d = PH_MINOR0;
          else if (digit)   maj_d   = sat_digit(maj_q, c);
          else if (blank)   phase_d = PH_MAJOR_SP;
        end
      end
      PH_MAJOR_SP: if (c == CH_DOT) phase_d = PH_MINOR0;
      PH_MINOR0, PH_MINOR: begin
        if (!((phase_q == PH_MINOR0) && blank)) begin
          phase_d = PH_MINOR;
          if (blank || (c == CH_CR)) phase_d = PH_END;
          else if (digit)            min_d   = sat_digit(min_q, c);
        end
      end
      default: ;
    endcase
    // Line events end the request
    if (too_big || bad) phase_d = PH_ERROR;
    else if (done)      phase_d = PH_DONE;
  end

  // Result bundle: field bytes first, then at most one event
  assign n_tot = RES_CNT_W'(d_n) + RES_CNT_W'(ev);

  always_comb begin
    enq_o.valid        = in_valid_i && !req_i.op && live && (n_tot != '0);
    enq_o.bundle.cnt   = n_tot;
    for (int i = 0; i < MAX_RES; i++) begin
      enq_o.bundle.res[i] = '{kind: KIND_ERROR, out_byte: 8'h00, major_version: 8'h00,
                              minor_version: 8'h00, error_code: ERR_BAD, last: 1'b0};
      if (i < 3 && RES_CNT_W'(i) < RES_CNT_W'(d_n)) begin
        enq_o.bundle.res[i].kind     = d_kind[i % 3];
        enq_o.bundle.res[i].out_byte = d_ch[i % 3];
      end else if (too_big) begin
        enq_o.bundle.res[i].error_code = ERR_LARGE;
      end else if (bad) begin
        enq_o.bundle.res[i].error_code = ERR_BAD;
      end else begin
        enq_o.bundle.res[i].kind          = KIND_DONE;
        enq_o.bundle.res[i].major_version = maj_q;
        enq_o.bundle.res[i].minor_version = min_q;
      end
      enq_o.bundle.res[i].last = (RES_CNT_W'(i) + RES_CNT_W'(1) == n_tot);
    end
  end

  assign cfg_ready_o = 1'b1;

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD0;
      nib_q   <= 4'h0;
      upper_q <= 1'b0;
      maj_q   <= 8'h00;
      min_q   <= 8'h00;
      cnt_q   <= '0;
    end else if (in_valid_i) begin
      if (req_i.op) begin
        phase_q <= PH_METHOD0;
        nib_q   <= 4'h0;
        upper_q <= 1'b0;
        maj_q   <= 8'h00;
        min_q   <= 8'h00;
        cnt_q   <= '0;
      end else if (live) begin
        phase_q <= phase_d;
        nib_q   <= nib_d;
        upper_q <= upper_d;
        maj_q   <= maj_d;
        min_q   <= min_d;
        cnt_q   <= cnt_inc;
      end
    end
  end

  // Request size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/hrlp_back.sv
// Back end: bundle queue and result sequencer; pop_i takes one result per cycle.
`default_nettype none

module hrlp_back
  import hrlp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire enq_t enq_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output res_t      out_o
);

  `include "http_request_line_parser_top_macros.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t              bund_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [RES_IDX_W-1:0] idx_q, idx_d;
  bundle_t              head;
  logic                 take, last_slot, deq;

  assign head      = bund_q[rd_ptr_q];
  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign out_o     = head.res[idx_q];
  assign take      = pop_i && !empty_o;
  assign last_slot = (RES_CNT_W'(idx_q) + RES_CNT_W'(1) == head.cnt);
  assign deq       = take && last_slot;

  // Pointer, fill and slot bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    idx_d    = idx_q;
    if (enq_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      idx_d    = '0;
    end else if (take) begin
      idx_d    = idx_q + RES_IDX_W'(1);
    end
    cnt_d = cnt_q + CNT_W'(enq_i.valid) - CNT_W'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  // Bundle storage
  always_ff @(posedge clk_i) begin
    if (enq_i.valid) begin
      bund_q[wr_ptr_q] <= enq_i.bundle;
    end
  end

  `HRLP_ASSERT(a_cnt_max, cnt_q <= CNT_W'(DEPTH), "queue fill above depth")
  `HRLP_ASSERT_IMP(a_no_overflow, enq_i.valid, !full_o, "bundle written into a full queue")
  `HRLP_ASSERT_IMP(a_head_cnt, !empty_o, head.cnt != '0, "empty bundle at queue head")
  `HRLP_ASSERT_IMP(a_idx_range, !empty_o, RES_CNT_W'(idx_q) < head.cnt, "slot past bundle")
  `HRLP_ASSERT_IMP(a_last_end, take && last_slot, out_o.last, "bundle end without last")

endmodule

`default_nettype wire

### rtl/http_request_line_parser_top.sv
// Top level of the HTTP request line parser.
// Usage:
//   Input queue side: drive in_i with push; a byte or restart is taken at a clock
//   edge where push is high and full is low. in_i.op = 1 restarts the parser.
//   Result queue side: while empty is low, out_o holds the oldest result; pop takes it.
//   Results carry method, URL and query bytes, then a line-complete or error event;
//   out_o.last flags the final result caused by one input byte.
//   Config: cfg_data_i sets the request byte limit (0 = unlimited) on a cycle with
//   cfg_valid_i high; cfg_ready_o is always high. Write only while the block is idle.
// Timing:
//   A byte's results are registered in the bundle queue and show once older results
//   have left. Bytes are taken one per cycle while full is low; results leave one per
//   cycle while pop is high, so a byte with k results (k up to 4) holds the result side
//   until all k are popped. The front end decodes one byte per cycle in its state machine;
//   the queue of QUEUE_DEPTH bundles sets how far the input can run ahead of the results.
// Reset and stall:
//   Reset clears the limit, puts the parser at the method start and empties the queue.
//   When pop stays low the queue fills and full rises, holding off further input.
`default_nettype none

module http_request_line_parser_top
  import hrlp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire req_t             in_i,
  output logic                  empty,
  input  wire logic             pop,
  output res_t                  out_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  enq_t enq;
  logic in_valid;

  assign in_valid = push && !full;

  hrlp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .req_i       (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .enq_o       (enq)
  );

  hrlp_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### tb/sv/request_line_checker.sv
// Request line parser checker: mirrors the parse state, predicts results and compares them.
module request_line_checker
  import hrlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  req_t              req_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  res_t              res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       open_cnt_o
);

  // Mirrored parser state
  phase_e      ph;
  logic [3:0]  esc_nib;
  logic        esc_upper;
  logic [7:0]  major_acc;
  logic [7:0]  minor_acc;
  logic [31:0] byte_cnt;
  logic [31:0] byte_limit;
  logic        step_bad;
  logic        step_done;

  res_t        step_q[$];    // results of the byte being parsed
  res_t        parsed_q[$];  // results still owed by the block
  int unsigned mismatches = 0;

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Token letters plus the separator set
  function automatic logic is_tok(logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
      return 1'b1;
    case (c)
      "\"", "(", ")", ",", "/", ":", ";", "<", "=", ">", "?", "@", "[", "\\", "]", "{", "}":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nib(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= "0" && c <= "9") begin
      t = c - CH_ZERO;
    end else if (c >= "a" && c <= "f") begin
      t = c - CH_LC_A + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      t = c - CH_UC_A + 8'd10;
    end else begin
      return 5'd0;
    end
    return {1'b1, t[3:0]};
  endfunction

  // Decimal accumulate, saturating at 255
  function automatic logic [7:0] dec_sat(logic [7:0] acc, logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - CH_ZERO);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  task automatic put_result(kind_e k, logic [7:0] b, logic [7:0] maj, logic [7:0] mnr,
                            logic err);
    res_t r;
    r.kind          = k;
    r.out_byte      = b;
    r.major_version = maj;
    r.minor_version = mnr;
    r.error_code    = err;
    r.last          = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic put_url(logic [7:0] b);
    put_result(KIND_URL, b, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic clear_parse();
    ph        = PH_METHOD0;
    esc_nib   = 4'h0;
    esc_upper = 1'b0;
    major_acc = 8'h00;
    minor_acc = 8'h00;
    byte_cnt  = 32'h0;
  endtask

  // URL byte past the first one
  task automatic url_body(logic [7:0] c);
    if (c == CH_QMARK) ph = PH_QUERY;
    else if (c == CH_CR) ph = PH_END;
    else if (c == CH_LF) step_done = 1'b1;
    else if (is_blank(c)) ph = PH_VERSION;
    else if (c == CH_PLUS) put_url(CH_SP);
    else if (c == CH_PCT) ph = PH_ESC1;
    else if (c > CH_SP && c < CH_HIGH) put_url(c);
    else step_bad = 1'b1;
  endtask

  task automatic major_step(logic [7:0] c);
    if (c == CH_DOT) ph = PH_MINOR0;
    else if (is_digit(c)) major_acc = dec_sat(major_acc, c);
    else if (is_blank(c)) ph = PH_MAJOR_SP;
    else step_bad = 1'b1;
  endtask

  task automatic minor_step(logic [7:0] c);
    if (c == CH_LF) step_done = 1'b1;
    else if (is_blank(c) || c == CH_CR) ph = PH_END;
    else if (is_digit(c)) minor_acc = dec_sat(minor_acc, c);
    else step_bad = 1'b1;
  endtask

  // Advance the mirrored parser by one request and queue what it yields
  task automatic parse_byte(req_t r);
    logic [7:0] c;
    logic [7:0] d;
    logic [4:0] h;
    c = r.data_byte;
    step_bad  = 1'b0;
    step_done = 1'b0;
    step_q.delete();
    if (r.op) begin
      clear_parse();
    end else if (ph != PH_DONE && ph != PH_ERROR) begin
      case (ph)
        PH_METHOD0: begin
          if (is_tok(c)) begin
            put_result(KIND_METHOD, c, 8'h00, 8'h00, 1'b0);
            ph = PH_METHOD;
          end else if (!is_blank(c)) begin
            step_bad = 1'b1;
          end
        end
        PH_METHOD: begin
          if (is_tok(c)) put_result(KIND_METHOD, c, 8'h00, 8'h00, 1'b0);
          else if (c == CH_SP) ph = PH_URL0;
          else step_bad = 1'b1;
        end
        PH_URL0: begin
          // first URL byte is literal
          if (c > CH_SP && c < CH_HIGH) begin
            put_url(c);
            ph = PH_URL;
          end else if (!is_blank(c)) begin
            step_bad = 1'b1;
          end
        end
        PH_URL: url_body(c);
        PH_ESC1: begin
          h = hex_nib(c);
          if (h[4]) begin
            esc_nib   = h[3:0];
            esc_upper = (c >= "A" && c <= "F");
            ph        = PH_ESC2;
          end else begin
            put_url(CH_PCT);
            ph = PH_URL;
            url_body(c);
          end
        end
        PH_ESC2: begin
          h = hex_nib(c);
          if (h[4]) begin
            put_url({esc_nib, h[3:0]});
            ph = PH_URL;
          end else begin
            // broken escape: give back '%' and the digit in its original case
            if (esc_nib < 4'd10) d = CH_ZERO + esc_nib;
            else d = (esc_upper ? CH_UC_A : CH_LC_A) + esc_nib - 8'd10;
            put_url(CH_PCT);
            put_url(d);
            ph = PH_URL;
            url_body(c);
          end
          esc_nib   = 4'h0;
          esc_upper = 1'b0;
        end
        PH_QUERY: begin
          if (is_blank(c)) ph = PH_VERSION;
          else put_result(KIND_QUERY, c, 8'h00, 8'h00, 1'b0);
        end
        PH_VERSION: begin
          if (c == CH_SLASH) begin
            major_acc = 8'h00;
            minor_acc = 8'h00;
            ph        = PH_MAJOR0;
          end else if (c == CH_CR) begin
            step_bad = 1'b1;
          end
        end
        PH_MAJOR0: begin
          if (!is_blank(c)) begin
            ph = PH_MAJOR;
            major_step(c);
          end
        end
        PH_MAJOR: major_step(c);
        PH_MAJOR_SP: begin
          if (c == CH_DOT) ph = PH_MINOR0;
          else step_bad = 1'b1;
        end
        PH_MINOR0: begin
          if (!is_blank(c)) begin
            ph = PH_MINOR;
            minor_step(c);
          end
        end
        PH_MINOR: minor_step(c);
        default: begin
          if (c == CH_LF) step_done = 1'b1;
          else if (!is_blank(c)) step_bad = 1'b1;
        end
      endcase

      // byte limit wins over any other event of this byte
      if (byte_cnt != 32'hFFFF_FFFF) byte_cnt = byte_cnt + 32'd1;
      if (byte_limit != 32'h0 && byte_cnt > byte_limit) begin
        ph = PH_ERROR;
        put_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, ERR_LARGE);
      end else if (step_bad) begin
        ph = PH_ERROR;
        put_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, ERR_BAD);
      end else if (step_done) begin
        ph = PH_DONE;
        put_result(KIND_DONE, 8'h00, major_acc, minor_acc, 1'b0);
      end
    end

    foreach (step_q[i]) begin
      res_t e;
      e = step_q[i];
      e.last = (i == step_q.size() - 1);
      parsed_q.push_back(e);
    end
  endtask

  task automatic report(logic owed, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (owed)
        $display("%0t result mismatch: want kind=%0d byte=%h maj=%0d min=%0d err=%b last=%b",
                 $time, want.kind, want.out_byte, want.major_version, want.minor_version,
                 want.error_code, want.last);
      else
        $display("%0t result mismatch: nothing owed", $time);
      $display("%0t                   got  kind=%0d byte=%h maj=%0d min=%0d err=%b last=%b",
               $time, got.kind, got.out_byte, got.major_version, got.minor_version,
               got.error_code, got.last);
    end
  endtask

  // Compare a popped result with the oldest owed one
  task automatic check_result(res_t got);
    res_t want;
    if (parsed_q.size() == 0) begin
      want = '0;
      report(1'b0, want, got);
    end else begin
      want = parsed_q.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.major_version !== want.major_version ||
          got.minor_version !== want.minor_version ||
          got.error_code !== want.error_code || got.last !== want.last)
        report(1'b1, want, got);
    end
  endtask

  // Watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      byte_limit = 32'h0;
      parsed_q.delete();
      open_cnt_o     <= 0;
      mismatch_cnt_o <= mismatches;
    end else begin
      if (pop_i && !empty_i) check_result(res_i);
      if (cfg_valid_i && cfg_ready_i) byte_limit = cfg_data_i;
      if (push_i && !full_i) parse_byte(req_i);
      open_cnt_o     <= parsed_q.size();
      mismatch_cnt_o <= mismatches;
    end
  end

endmodule

### tb/sv/tb.sv
// Testbench top for the request line parser: stimulus, result draining and verdict.
module tb;
  import hrlp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             push      = 1'b0;
  logic             full;
  req_t             req       = '0;
  logic             empty;
  logic             pop       = 1'b0;
  res_t             res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  logic             calm      = 1'b0;   // no idling on either side while set
  int unsigned      mismatch_cnt;
  int unsigned      open_cnt;
  int unsigned      quiet     = 0;
  logic [7:0]       line_q[$];

  always #6 clk = ~clk;

  http_request_line_parser_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_i        (req),
    .empty       (empty),
    .pop         (pop),
    .out_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  request_line_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push_i         (push),
    .full_i         (full),
    .req_i          (req),
    .empty_i        (empty),
    .pop_i          (pop),
    .res_i          (res),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatch_cnt),
    .open_cnt_o     (open_cnt)
  );

  // Result side: random stalls
  always @(posedge clk) begin
    pop <= calm || ($urandom_range(99) >= 12);
  end

  // Watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] any_blank();
    return $urandom_range(1) ? CH_SP : CH_TAB;
  endfunction

  function automatic logic [7:0] method_char();
    string seps;
    seps = "\"(),/:;<=>?@[\\]{}";
    if ($urandom_range(5) == 0) return seps[$urandom_range(seps.len() - 1)];
    return $urandom_range(1) ? 8'(CH_UC_A + $urandom_range(25))
                             : 8'(CH_LC_A + $urandom_range(25));
  endfunction

  function automatic logic [7:0] hex_char();
    string hexs;
    hexs = "0123456789abcdefABCDEF";
    return hexs[$urandom_range(hexs.len() - 1)];
  endfunction

  // Bytes that break an escape, blanks and line ends among them
  function automatic logic [7:0] non_hex();
    string s;
    s = "ghzGZ/.-_~+%?\r\n\t ";
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] query_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == CH_SP || b == CH_TAB) ? 8'h78 : b;
  endfunction

  task automatic push_digits(int unsigned n);
    repeat (n) line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
  endtask

  // Mostly well-formed request line with random content, some of it damaged
  task automatic make_line();
    int unsigned pick;
    string proto;
    proto = "HTTP";
    line_q.delete();
    if ($urandom_range(4) == 0) line_q.push_back(any_blank());
    repeat ($urandom_range(1, 4)) line_q.push_back(method_char());
    line_q.push_back(CH_SP);
    if ($urandom_range(4) == 0) line_q.push_back(any_blank());

    // URL body: plain bytes, plus signs, good and broken escapes
    line_q.push_back($urandom_range(3) == 0 ? 8'($urandom_range(8'h21, 8'h7E)) : CH_SLASH);
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end else if (pick == 5) begin
        line_q.push_back(CH_PLUS);
      end else begin
        line_q.push_back(CH_PCT);
        line_q.push_back(pick == 8 ? non_hex() : hex_char());
        if (pick != 8) line_q.push_back(pick == 9 ? non_hex() : hex_char());
      end
    end
    if ($urandom_range(9) < 4) begin
      line_q.push_back(CH_QMARK);
      repeat ($urandom_range(0, 4)) line_q.push_back(query_byte());
    end

    // Line end right after the URL, or a version
    pick = $urandom_range(9);
    if (pick == 0) begin
      line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end else if (pick == 1) begin
      line_q.push_back(CH_LF);
    end else begin
      line_q.push_back(any_blank());
      for (int i = 0; i < proto.len(); i++)
        line_q.push_back($urandom_range(9) == 0 ? 8'($urandom_range(255)) : proto[i]);
      line_q.push_back(CH_SLASH);
      if ($urandom_range(9) == 0) line_q.push_back(any_blank());
      push_digits($urandom_range(9) == 0 ? 4 : $urandom_range(1, 2));
      if ($urandom_range(9) == 0) line_q.push_back(any_blank());
      line_q.push_back(CH_DOT);
      if ($urandom_range(9) == 0) line_q.push_back(any_blank());
      push_digits($urandom_range(9) == 0 ? 4 : $urandom_range(1, 2));
      pick = $urandom_range(3);
      if (pick >= 2) line_q.push_back(any_blank());
      if (pick != 1 && pick != 2) line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end

    // Damage: one random byte, or a cut-off line
    pick = $urandom_range(99);
    if (pick < 12) begin
      line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
    end else if (pick < 18) begin
      pick = $urandom_range(line_q.size() - 1);
      while (line_q.size() > pick) void'(line_q.pop_back());
    end
  endtask

  // One request on the input side, with random idle cycles ahead of it
  task automatic send_req(logic op, logic [7:0] b);
    req_t r;
    r.op        = op;
    r.data_byte = b;
    while (!calm && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req  <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_req(1'b0, s[i]);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      make_line();
      if ($urandom_range(9) != 0) send_req(1'b1, 8'($urandom_range(255)));
      foreach (line_q[i]) send_req(1'b0, line_q[i]);
      sent += line_q.size();
      // trailing bytes after the line ends
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 2)) send_req(1'b0, 8'($urandom_range(255)));
    end
  endtask

  // Drain: all owed results out, then room for bytes that yield nothing
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed line: broken escapes, literal first URL byte, raw query, saturated major
    send_req(1'b1, 8'hFF);
    send_text("\tM +%g%4q%4a?");
    send_req(1'b0, CH_HIGH);
    send_text("\r /300.9\nX");
    run_random(70);

    // Smallest nonzero limit
    write_limit(32'd1);
    run_random(20);

    // Largest limit, first half without any idling
    write_limit(32'hFFFF_FFFF);
    calm = 1'b1;
    run_random(45);
    calm = 1'b0;
    run_random(45);

    // Limit inside a typical line length
    write_limit(32'($urandom_range(10, 40)));
    run_random(90);

    write_limit(32'd0);
    run_random(70);

    settle();
    if (mismatch_cnt == 0 && open_cnt == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

### http_request_line_parser_top.f
+incdir+rtl
rtl/hrlp_pkg.sv
rtl/hrlp_front.sv
rtl/hrlp_back.sv
rtl/http_request_line_parser_top.sv
tb/sv/request_line_checker.sv
tb/sv/tb.sv
